FILE: sv/ordered_linear_probe_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered linear probe hash table
// Implication checks on the rising edge of clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define ORDERED_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef SYNTH
`define OLPHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olpht same-cycle check failed");
`define OLPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olpht next-cycle check failed");
`else
`define OLPHT_ASSERT_SAME(label, ante, cons)
`define OLPHT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/olpht_pkg.sv
// ----------------------------------------------------------------------------
// olpht_pkg
// Types, constants and slot index helpers for the ordered linear probe table.
// ----------------------------------------------------------------------------
package olpht_pkg;

  // Slot count must be a power of two: index arithmetic wraps on IDX_W bits.
  localparam int SLOTS = 128;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int KEY_W = 64;
  localparam int CNT_W = IDX_W + 1;

  localparam logic [KEY_W-1:0] TOMB_KEY  = '1;
  localparam logic [KEY_W-1:0] EMPTY_KEY = '0;
  localparam logic [63:0]      MIX_M     = 64'hc6a4a7935bd1e995;
  localparam int               MIX_R     = 47;
  // seed 0, length 8: h starts at 8 * M
  localparam logic [63:0]      HASH_INIT = MIX_M << 3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic hit;
    logic table_full;
  } rsp_t;

  typedef struct packed {
    idx_t             home;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_INS_RD,
    ST_INS_EV,
    ST_FWD_RD,
    ST_FWD_WR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_BACK_RD,
    ST_BACK_WR,
    ST_PLACE,
    ST_DONE
  } state_t;

  function automatic idx_t slot_next(idx_t i);
    return i + idx_t'(1);
  endfunction

  function automatic idx_t slot_prev(idx_t i);
    return i - idx_t'(1);
  endfunction

  // resident at slot i with home hk sits circularly in (h, i]
  function automatic logic homed_after(idx_t h, idx_t hk, idx_t i);
    idx_t dk;
    idx_t di;
    dk = hk - h;
    di = i - h;
    return (dk != '0) && (dk <= di);
  endfunction

endpackage

FILE: sv/olpht_ram.sv
// ----------------------------------------------------------------------------
// olpht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module olpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/olpht_hash.sv
// ----------------------------------------------------------------------------
// olpht_hash
// MurmurHash64A of one 64-bit key, seed 0, on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module olpht_hash
  import olpht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output idx_t             home
);

  logic        running;
  logic [1:0]  mul_idx;
  logic [1:0]  part;
  logic [63:0] opnd;
  logic [63:0] acc;
  logic [31:0] a_half;
  logic [31:0] m_half;
  logic [63:0] prod;
  logic [63:0] mix;

  // 64x64 low product: lo*lo, then the two cross terms shifted up 32
  always_comb begin
    a_half = (part == 2'd1) ? opnd[63:32] : opnd[31:0];
    m_half = (part == 2'd2) ? MIX_M[63:32] : MIX_M[31:0];
    prod   = 64'(a_half) * 64'(m_half);
    mix    = acc ^ (acc >> MIX_R);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      part    <= 2'd0;
      mul_idx <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        opnd    <= key;
        part    <= 2'd0;
        mul_idx <= 2'd0;
      end else if (running) begin
        unique case (part)
          2'd0: begin
            acc  <= prod;
            part <= 2'd1;
          end
          2'd1: begin
            acc  <= acc + {prod[31:0], 32'b0};
            part <= 2'd2;
          end
          2'd2: begin
            acc  <= acc + {prod[31:0], 32'b0};
            part <= 2'd3;
          end
          2'd3: begin
            part    <= 2'd0;
            mul_idx <= mul_idx + 2'd1;
            unique case (mul_idx)
              2'd0: opnd <= mix;
              2'd1: opnd <= HASH_INIT ^ acc;
              2'd2: opnd <= mix;
              2'd3: begin
                // modulo a power-of-two slot count keeps the low bits
                home    <= mix[IDX_W-1:0];
                running <= 1'b0;
                done    <= 1'b1;
              end
            endcase
          end
        endcase
      end
    end
  end

  `include "ordered_linear_probe_hash_table_assert.svh"

  `OLPHT_ASSERT_SAME(a_no_restart, running, !start)
  `OLPHT_ASSERT_NEXT(a_start_runs, start, running && !done)
  `OLPHT_ASSERT_SAME(a_done_idle, done, !running)

endmodule

FILE: sv/ordered_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// ordered_linear_probe_hash_table
// Set of 64-bit keys kept by ordered linear probing with tombstones.
// ----------------------------------------------------------------------------
// One item at a time. An item first passes the hash stage (four 64-bit
// multiplies on one 32x32 multiplier), then probes slot by slot through the
// registered-read slot RAM, with a read and a write per slot moved when an
// insert shifts a run, a write to place the key and a last step to post the
// result. Reserved keys and the unused opcode skip the hash and go straight
// to the result.
// Slot occupancy is tracked in per-slot valid flops cleared by reset, so the
// table is usable right after reset. The home slot of each key is stored
// with it, so residents are never rehashed.
module ordered_linear_probe_hash_table
  import olpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t           state;
  state_t           state_next;
  opcode_t          op_q;
  logic [KEY_W-1:0] key_q;
  idx_t             home_q;
  idx_t             i_q;
  idx_t             j_q;
  idx_t             p_q;
  idx_t             last_q;
  logic             have_p;
  logic [CNT_W-1:0] cnt;
  logic             res_hit;
  logic             res_full;
  logic [SLOTS-1:0] slot_valid;
  logic             rd_valid;

  logic             hash_start;
  logic             hash_done;
  idx_t             hash_home;

  logic             ram_we;
  idx_t             ram_waddr;
  slot_t            ram_wdata;
  idx_t             ram_raddr;
  slot_t            rd_slot;

  logic             accept;
  logic             reserved;
  logic             rd_tomb;
  logic             rd_stop;
  logic             rd_match;
  logic             last_step;
  idx_t             eval_idx;
  idx_t             ins_dst;
  idx_t             scan_stop;
  idx_t             scan_last;
  logic             scan_end;

  assign accept   = req_valid && req_ready;
  assign reserved = (req.key == EMPTY_KEY) || (req.key == TOMB_KEY) || (req.opcode == OP_NOP);

  olpht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_q),
    .done  (hash_done),
    .home  (hash_home)
  );

  olpht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_slot)
  );

  // evaluation of the slot just read
  always_comb begin
    eval_idx  = (state == ST_SCAN_EV) ? j_q : i_q;
    rd_tomb   = rd_valid && (rd_slot.key == TOMB_KEY);
    rd_stop   = !rd_valid || (!rd_tomb && homed_after(home_q, rd_slot.home, eval_idx));
    rd_match  = rd_valid && (rd_slot.key == key_q);
    last_step = (cnt == CNT_W'(SLOTS - 1));
    ins_dst   = have_p ? p_q : i_q;
    scan_stop = rd_stop ? j_q : slot_next(j_q);
    scan_end  = rd_stop || (slot_next(j_q) == home_q);
    scan_last = slot_prev(scan_stop);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = reserved ? ST_DONE : ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_next = (op_q == OP_INSERT) ? ST_INS_RD : ST_FIND_RD;
        end
      end
      ST_FIND_RD: state_next = ST_FIND_EV;
      ST_FIND_EV: begin
        if (rd_stop || rd_match || last_step) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FIND_RD;
        end
      end
      ST_INS_RD: state_next = ST_INS_EV;
      ST_INS_EV: begin
        priority if (!rd_valid || (rd_tomb && have_p)) begin
          state_next = (ins_dst == i_q) ? ST_PLACE : ST_FWD_RD;
        end else if (rd_tomb) begin
          state_next = (slot_next(i_q) == home_q) ? ST_PLACE : ST_SCAN_RD;
        end else if (last_step) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_INS_RD;
        end
      end
      ST_FWD_RD: state_next = ST_FWD_WR;
      ST_FWD_WR: begin
        state_next = (slot_prev(j_q) == last_q) ? ST_PLACE : ST_FWD_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (scan_end) begin
          state_next = (scan_last == i_q) ? ST_PLACE : ST_BACK_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_BACK_RD: state_next = ST_BACK_WR;
      ST_BACK_WR: begin
        state_next = (slot_next(i_q) == last_q) ? ST_PLACE : ST_BACK_RD;
      end
      ST_PLACE: state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = (state == ST_IDLE);
    hash_start = 1'b0;
    ram_raddr  = i_q;
    ram_we     = 1'b0;
    ram_waddr  = i_q;
    ram_wdata  = rd_slot;
    unique case (state)
      ST_HASH:    hash_start = (cnt == '0) && !hash_done;
      ST_FWD_RD:  ram_raddr = slot_prev(j_q);
      ST_FWD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
      end
      ST_SCAN_RD: ram_raddr = j_q;
      ST_BACK_RD: ram_raddr = slot_next(i_q);
      ST_BACK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
      end
      ST_FIND_EV: begin
        // delete turns the found slot into a tombstone
        if (!rd_stop && rd_match && (op_q == OP_DELETE)) begin
          ram_we    = 1'b1;
          ram_waddr = i_q;
          ram_wdata = '{home: rd_slot.home, key: TOMB_KEY};
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = last_q;
        ram_wdata = '{home: home_q, key: key_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
      cnt        <= '0;
      have_p     <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      if ((state == ST_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            op_q     <= req.opcode;
            key_q    <= req.key;
            res_hit  <= 1'b0;
            res_full <= 1'b0;
            have_p   <= 1'b0;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            home_q <= hash_home;
            i_q    <= hash_home;
            cnt    <= '0;
          end else begin
            // cnt marks that the hash unit was started
            cnt <= CNT_W'(1);
          end
        end
        ST_FIND_EV: begin
          if (!rd_stop && rd_match) begin
            res_hit <= 1'b1;
          end else begin
            i_q <= slot_next(i_q);
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_INS_EV: begin
          priority if (!rd_valid || (rd_tomb && have_p)) begin
            j_q    <= i_q;
            last_q <= ins_dst;
          end else if (rd_tomb) begin
            j_q    <= slot_next(i_q);
            last_q <= i_q;
          end else begin
            if (!have_p && homed_after(home_q, rd_slot.home, i_q)) begin
              have_p <= 1'b1;
              p_q    <= i_q;
            end
            if (last_step) begin
              res_full <= 1'b1;
            end
            i_q <= slot_next(i_q);
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_FWD_WR:  j_q <= slot_prev(j_q);
        ST_SCAN_EV: begin
          j_q <= slot_next(j_q);
          if (scan_end) begin
            last_q <= scan_last;
          end
        end
        ST_BACK_WR: i_q <= slot_next(i_q);
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.hit        <= res_hit;
            rsp.table_full <= res_full;
          end
        end
        default: begin
        end
      endcase
      rd_valid <= slot_valid[ram_raddr];
    end
  end

  `include "ordered_linear_probe_hash_table_assert.svh"

  `OLPHT_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE)
  `OLPHT_ASSERT_SAME(a_no_write_idle, ram_we, state != ST_IDLE && state != ST_HASH)
  `OLPHT_ASSERT_SAME(a_hit_xor_full, rsp_valid, !(rsp.hit && rsp.table_full))
  `OLPHT_ASSERT_SAME(a_cnt_bound, state != ST_IDLE, cnt <= CNT_W'(SLOTS))
  `OLPHT_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid), $past(state) == ST_DONE)

endmodule
